FILE: sv/lcbb_pkg.sv
`default_nettype none
package lcbb_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [2:0] CMD_PUT      = 3'd0;
    localparam logic [2:0] CMD_GET      = 3'd1;
    localparam logic [2:0] CMD_REMOVE   = 3'd2;
    localparam logic [2:0] CMD_CONTAINS = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_PASS,
        S_EVICT,
        S_EVICT_W,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        M_PUT_HIT,
        M_PUT_NEW,
        M_TOUCH,
        M_REMOVE,
        M_CLEAR
    } mode_t;

    // one slot of the store
    typedef struct packed {
        logic [63:0]      key;
        logic [31:0]      handle;
        logic [31:0]      size;
        logic [IDX_W-1:0] rank;
    } entry_t;

    // scratch record, addressed by recency rank
    typedef struct packed {
        logic [63:0]      key;
        logic [31:0]      handle;
        logic [31:0]      size;
        logic [IDX_W-1:0] slot;
    } record_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage
`default_nettype wire

FILE: sv/lru_cache_byte_budget.sv
// Channel   Direction  Handshake               Word
// command   in         start & !busy           command, key, value_handle, entry_size
// result    out        result_strobe (1 cycle) record_kind .. insert_total, last
// config    in         max_bytes_we            max_bytes_wdata
//
// A command costs a key scan over the slot RAM, then for put/get-hit/remove/clear
// a rank read-modify-write pass, for a put a budget check that evicts the oldest
// entries while over budget, and then the result words, drop records first.
// The single read port of the slot RAM makes the scan and the pass sweep it slot by slot.
// Reset clears valid bits, counters and the budget; the RAMs need no clearing.
// Results cannot be stalled; busy drops in the cycle that shows the final word.
`default_nettype none
module lru_cache_byte_budget
    import lcbb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [2:0]       command,
    input  wire logic [63:0]      key,
    input  wire logic [31:0]      value_handle,
    input  wire logic [31:0]      entry_size,
    input  wire logic             max_bytes_we,
    input  wire logic [31:0]      max_bytes_wdata,
    output logic                  result_strobe,
    output logic                  record_kind,
    output logic [1:0]            status,
    output logic                  found,
    output logic [31:0]           value_out,
    output logic [63:0]           dropped_key,
    output logic [31:0]           used_bytes,
    output logic [CNT_W-1:0]      entries_held,
    output logic [31:0]           hit_total,
    output logic [31:0]           miss_total,
    output logic [31:0]           eviction_total,
    output logic [31:0]           insert_total,
    output logic                  last
);

    localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0] TOP_SLOT = IDX_W'(ENTRIES - 1);

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;

    // sweep counter and read pipeline tag
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic              rd_v_reg, rd_v_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;

    // latched command word
    logic [2:0]        cmd_reg, cmd_next;
    logic [63:0]       key_reg, key_next;
    logic [31:0]       vh_reg, vh_next;
    logic [31:0]       sz_reg, sz_next;

    logic [31:0]       max_reg, max_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [32:0]       bytes_reg, bytes_next;   // one spare bit while a put is over budget
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]       hits_reg, hits_next;
    logic [31:0]       miss_reg, miss_next;
    logic [31:0]       evs_reg, evs_next;
    logic [31:0]       ins_reg, ins_next;

    // scan result
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]  hit_rank_reg, hit_rank_next;
    logic [31:0]       hit_handle_reg, hit_handle_next;
    logic [31:0]       hit_size_reg, hit_size_next;
    logic [IDX_W-1:0]  tgt_reg, tgt_next;

    // response word
    logic [1:0]        rsp_status_reg, rsp_status_next;
    logic              rsp_found_reg, rsp_found_next;
    logic [31:0]       rsp_value_reg, rsp_value_next;

    // eviction and emission bookkeeping
    logic [CNT_W-1:0]  ev_n_reg, ev_n_next;
    logic [IDX_W-1:0]  em_addr_reg, em_addr_next;
    logic [CNT_W-1:0]  em_rem_reg, em_rem_next;
    logic              em_down_reg, em_down_next;
    logic              em_pend_reg, em_pend_next;

    // output word
    logic              o_stb_reg, o_stb_next;
    logic              o_kind_reg, o_kind_next;
    logic [1:0]        o_status_reg, o_status_next;
    logic              o_found_reg, o_found_next;
    logic [31:0]       o_value_reg, o_value_next;
    logic [63:0]       o_key_reg, o_key_next;
    logic              o_last_reg, o_last_next;

    // RAM ports
    logic              e_we;
    logic [IDX_W-1:0]  e_waddr, e_raddr;
    entry_t            e_wdata, e_rdata;
    logic              r_we;
    logic [IDX_W-1:0]  r_waddr, r_raddr;
    record_t           r_wdata, r_rdata;

    logic [IDX_W-1:0]  free_idx;
    logic              rd_valid;
    logic [IDX_W-1:0]  new_rank;

    lcbb_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_slots (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    lcbb_ram #(.WIDTH($bits(record_t)), .DEPTH(ENTRIES)) u_records (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign rd_valid = valid_reg[rd_idx_reg];

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        addr_next       = addr_reg;
        rd_v_next       = 1'b0;
        rd_idx_next     = addr_reg[IDX_W-1:0];
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        vh_next         = vh_reg;
        sz_next         = sz_reg;
        max_next        = max_bytes_we ? max_bytes_wdata : max_reg;
        valid_next      = valid_reg;
        bytes_next      = bytes_reg;
        cnt_next        = cnt_reg;
        hits_next       = hits_reg;
        miss_next       = miss_reg;
        evs_next        = evs_reg;
        ins_next        = ins_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        hit_handle_next = hit_handle_reg;
        hit_size_next   = hit_size_reg;
        tgt_next        = tgt_reg;
        rsp_status_next = rsp_status_reg;
        rsp_found_next  = rsp_found_reg;
        rsp_value_next  = rsp_value_reg;
        ev_n_next       = ev_n_reg;
        em_addr_next    = em_addr_reg;
        em_rem_next     = em_rem_reg;
        em_down_next    = em_down_reg;
        em_pend_next    = 1'b0;
        o_stb_next      = 1'b0;
        o_kind_next     = o_kind_reg;
        o_status_next   = o_status_reg;
        o_found_next    = o_found_reg;
        o_value_next    = o_value_reg;
        o_key_next      = o_key_reg;
        o_last_next     = o_last_reg;

        e_we     = 1'b0;
        e_waddr  = rd_idx_reg;
        e_wdata  = e_rdata;
        e_raddr  = addr_reg[IDX_W-1:0];
        r_we     = 1'b0;
        r_waddr  = e_rdata.rank;
        r_wdata  = '{key: e_rdata.key, handle: e_rdata.handle,
                     size: e_rdata.size, slot: rd_idx_reg};
        r_raddr  = em_addr_reg;
        new_rank = e_rdata.rank;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next       = command;
                    key_next       = key;
                    vh_next        = value_handle;
                    sz_next        = entry_size;
                    hit_next       = 1'b0;
                    addr_next      = '0;
                    ev_n_next      = '0;
                    em_rem_next    = '0;
                    rsp_status_next = ST_OK;
                    rsp_found_next = 1'b0;
                    rsp_value_next = '0;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (addr_reg != N_CNT)
                begin
                    rd_v_next = 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
                else if (!rd_v_reg)
                begin
                    state_next = S_DECIDE;
                end
                if (rd_v_reg && rd_valid && e_rdata.key == key_reg)
                begin
                    hit_next        = 1'b1;
                    hit_idx_next    = rd_idx_reg;
                    hit_rank_next   = e_rdata.rank;
                    hit_handle_next = e_rdata.handle;
                    hit_size_next   = e_rdata.size;
                end
            end

            S_DECIDE:
            begin
                addr_next  = '0;
                tgt_next   = hit_idx_reg;
                state_next = S_EMIT;
                case (cmd_reg)
                    CMD_PUT:
                    begin
                        if (vh_reg == '0)
                        begin
                            rsp_status_next = ST_INVALID;
                        end
                        else if (hit_reg)
                        begin
                            bytes_next = bytes_reg - {1'b0, hit_size_reg} + {1'b0, sz_reg};
                            mode_next  = M_PUT_HIT;
                            state_next = S_PASS;
                        end
                        else if (cnt_reg >= N_CNT)
                        begin
                            rsp_status_next = ST_FULL;
                        end
                        else
                        begin
                            tgt_next             = free_idx;
                            valid_next[free_idx] = 1'b1;
                            bytes_next           = bytes_reg + {1'b0, sz_reg};
                            cnt_next             = cnt_reg + 1'b1;
                            ins_next             = sat_inc(ins_reg);
                            mode_next            = M_PUT_NEW;
                            state_next           = S_PASS;
                        end
                    end
                    CMD_GET:
                    begin
                        if (hit_reg)
                        begin
                            hits_next      = sat_inc(hits_reg);
                            rsp_found_next = 1'b1;
                            rsp_value_next = hit_handle_reg;
                            mode_next      = M_TOUCH;
                            state_next     = S_PASS;
                        end
                        else
                        begin
                            miss_next       = sat_inc(miss_reg);
                            rsp_status_next = ST_NOT_FOUND;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                            bytes_next   = bytes_reg - {1'b0, hit_size_reg};
                            cnt_next     = cnt_reg - 1'b1;
                            em_addr_next = TOP_SLOT;
                            em_rem_next  = CNT_W'(1);
                            mode_next    = M_REMOVE;
                            state_next   = S_PASS;
                        end
                        else
                        begin
                            rsp_status_next = ST_NOT_FOUND;
                        end
                    end
                    CMD_CONTAINS:
                    begin
                        rsp_found_next = hit_reg;
                    end
                    CMD_CLEAR:
                    begin
                        em_addr_next = '0;
                        em_rem_next  = cnt_reg;
                        em_down_next = 1'b0;
                        mode_next    = M_CLEAR;
                        state_next   = S_PASS;
                    end
                    default:
                    begin
                        rsp_status_next = ST_INVALID;
                    end
                endcase
            end

            S_PASS:
            begin
                if (addr_reg != N_CNT)
                begin
                    rd_v_next = 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
                else if (!rd_v_reg)
                begin
                    case (mode_reg)
                        M_PUT_HIT, M_PUT_NEW: state_next = S_EVICT;
                        M_CLEAR:
                        begin
                            valid_next = '0;
                            bytes_next = '0;
                            cnt_next   = '0;
                            state_next = S_EMIT;
                        end
                        default: state_next = S_EMIT;
                    endcase
                end
                if (rd_v_reg)
                begin
                    case (mode_reg)
                        M_PUT_HIT, M_PUT_NEW, M_TOUCH:
                        begin
                            if (rd_idx_reg == tgt_reg)
                            begin
                                new_rank = '0;
                                if (mode_reg != M_TOUCH)
                                begin
                                    e_wdata.key    = key_reg;
                                    e_wdata.handle = vh_reg;
                                    e_wdata.size   = sz_reg;
                                end
                                e_we = 1'b1;
                            end
                            else if (rd_valid)
                            begin
                                if (mode_reg == M_PUT_NEW || e_rdata.rank < hit_rank_reg)
                                begin
                                    new_rank = e_rdata.rank + 1'b1;
                                end
                                e_we = 1'b1;
                            end
                            e_wdata.rank   = new_rank;
                            r_we           = e_we;
                            r_waddr        = new_rank;
                            r_wdata.key    = e_wdata.key;
                            r_wdata.handle = e_wdata.handle;
                            r_wdata.size   = e_wdata.size;
                        end
                        M_REMOVE:
                        begin
                            if (rd_idx_reg == tgt_reg)
                            begin
                                r_we    = 1'b1;
                                r_waddr = TOP_SLOT;
                            end
                            else if (rd_valid && e_rdata.rank > hit_rank_reg)
                            begin
                                e_wdata.rank = e_rdata.rank - 1'b1;
                                e_we         = 1'b1;
                            end
                        end
                        default:
                        begin
                            r_we = rd_valid;
                        end
                    endcase
                end
            end

            S_EVICT:
            begin
                if (cnt_reg != '0 && bytes_reg > {1'b0, max_reg})
                begin
                    r_raddr    = cnt_reg[IDX_W-1:0] - 1'b1;
                    state_next = S_EVICT_W;
                end
                else
                begin
                    // oldest first: highest rank down
                    em_addr_next = cnt_reg[IDX_W-1:0] + ev_n_reg[IDX_W-1:0] - 1'b1;
                    em_rem_next  = ev_n_reg;
                    em_down_next = 1'b1;
                    state_next   = S_EMIT;
                end
            end

            S_EVICT_W:
            begin
                valid_next[r_rdata.slot] = 1'b0;
                bytes_next = bytes_reg - {1'b0, r_rdata.size};
                cnt_next   = cnt_reg - 1'b1;
                ev_n_next  = ev_n_reg + 1'b1;
                evs_next   = sat_inc(evs_reg);
                state_next = S_EVICT;
            end

            S_EMIT:
            begin
                if (em_rem_reg != '0)
                begin
                    em_pend_next = 1'b1;
                    em_rem_next  = em_rem_reg - 1'b1;
                    em_addr_next = em_down_reg ? em_addr_reg - 1'b1 : em_addr_reg + 1'b1;
                end
                if (em_pend_reg)
                begin
                    o_stb_next    = 1'b1;
                    o_kind_next   = 1'b1;
                    o_status_next = ST_OK;
                    o_found_next  = 1'b0;
                    o_value_next  = r_rdata.handle;
                    o_key_next    = r_rdata.key;
                    o_last_next   = 1'b0;
                end
                else if (em_rem_reg == '0)
                begin
                    o_stb_next    = 1'b1;
                    o_kind_next   = 1'b0;
                    o_status_next = rsp_status_reg;
                    o_found_next  = rsp_found_reg;
                    o_value_next  = rsp_value_reg;
                    o_key_next    = '0;
                    o_last_next   = 1'b1;
                    em_down_next  = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= M_TOUCH;
            addr_reg       <= '0;
            rd_v_reg       <= 1'b0;
            max_reg        <= '0;
            valid_reg      <= '0;
            bytes_reg      <= '0;
            cnt_reg        <= '0;
            hits_reg       <= '0;
            miss_reg       <= '0;
            evs_reg        <= '0;
            ins_reg        <= '0;
            hit_reg        <= 1'b0;
            ev_n_reg       <= '0;
            em_rem_reg     <= '0;
            em_down_reg    <= 1'b0;
            em_pend_reg    <= 1'b0;
            o_stb_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            addr_reg       <= addr_next;
            rd_v_reg       <= rd_v_next;
            max_reg        <= max_next;
            valid_reg      <= valid_next;
            bytes_reg      <= bytes_next;
            cnt_reg        <= cnt_next;
            hits_reg       <= hits_next;
            miss_reg       <= miss_next;
            evs_reg        <= evs_next;
            ins_reg        <= ins_next;
            hit_reg        <= hit_next;
            ev_n_reg       <= ev_n_next;
            em_rem_reg     <= em_rem_next;
            em_down_reg    <= em_down_next;
            em_pend_reg    <= em_pend_next;
            o_stb_reg      <= o_stb_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= rd_idx_next;
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        vh_reg          <= vh_next;
        sz_reg          <= sz_next;
        hit_idx_reg     <= hit_idx_next;
        hit_rank_reg    <= hit_rank_next;
        hit_handle_reg  <= hit_handle_next;
        hit_size_reg    <= hit_size_next;
        tgt_reg         <= tgt_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_found_reg   <= rsp_found_next;
        rsp_value_reg   <= rsp_value_next;
        em_addr_reg     <= em_addr_next;
        o_kind_reg      <= o_kind_next;
        o_status_reg    <= o_status_next;
        o_found_reg     <= o_found_next;
        o_value_reg     <= o_value_next;
        o_key_reg       <= o_key_next;
        o_last_reg      <= o_last_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign result_strobe  = o_stb_reg;
    assign record_kind    = o_kind_reg;
    assign status         = o_status_reg;
    assign found          = o_found_reg;
    assign value_out      = o_value_reg;
    assign dropped_key    = o_key_reg;
    assign last           = o_last_reg;
    // totals are final before the first word of a command is shown
    assign used_bytes     = bytes_reg[31:0];
    assign entries_held   = cnt_reg;
    assign hit_total      = hits_reg;
    assign miss_total     = miss_reg;
    assign eviction_total = evs_reg;
    assign insert_total   = ins_reg;

endmodule
`default_nettype wire

FILE: sv/lcbb_ram.sv
`default_nettype none
module lcbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
